// ===== rtl/arp_pkg.sv =====
// ----------------------------------------------------------------------------
// arp_pkg
// Shared types and codes for the aging resource pool.
// ----------------------------------------------------------------------------
package arp_pkg;

  localparam int FRAME_BITS = 32;
  localparam int AGE_BITS   = 8;
  localparam int WORD_BITS  = 32;
  localparam int CNT_BITS   = 5;

  // func codes
  localparam logic [1:0] FN_ALLOC   = 2'd0;
  localparam logic [1:0] FN_RELEASE = 2'd1;
  localparam logic [1:0] FN_TICK    = 2'd2;

  // status codes
  localparam logic [2:0] ST_REUSED    = 3'd0;
  localparam logic [2:0] ST_CREATED   = 3'd1;
  localparam logic [2:0] ST_RELEASED  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;
  localparam logic [2:0] ST_TICK_DONE = 3'd5;

  localparam logic [FRAME_BITS-1:0] FRAME_MAX = '1;

  typedef enum logic {CMP_EQ, CMP_LT} cmp_op_t;

  typedef struct packed {
    logic [1:0]           func;
    logic [WORD_BITS-1:0] handle;
  } arp_in_t;

  typedef struct packed {
    logic [2:0]           status;
    logic [WORD_BITS-1:0] handle_out;
    logic [CNT_BITS-1:0]  evicted;
    logic [CNT_BITS-1:0]  entries;
  } arp_out_t;

  // table control strobes from the sequencer
  typedef struct packed {
    logic rd_en;    // read frame and handle at rd_addr
    logic lf_we;    // write last-frame at wr_addr
    logic hd_we;    // write handle at wr_addr
    logic act_we;   // write active bit at wr_addr
    logic act_val;
    logic act_clr;  // clear active bit at clr_addr (wins over act_we)
  } tbl_ctl_t;

endpackage

// ===== rtl/arp_cmp_unit.sv =====
// ----------------------------------------------------------------------------
// arp_cmp_unit
// Shared compare unit: handle equality or aged-frame less-than.
// ----------------------------------------------------------------------------
module arp_cmp_unit #(
  parameter int W = 33
) (
  input  arp_pkg::cmp_op_t              op,
  input  logic [W-1:0]                  a,
  input  logic [arp_pkg::AGE_BITS-1:0]  addend,
  input  logic [W-1:0]                  b,
  output logic                          hit
);
  import arp_pkg::*;

  logic [W-1:0] sum;

  // a holds at most a frame value, so the sum cannot wrap at W >= 33
  assign sum = a + W'(addend);
  assign hit = (op == CMP_EQ) ? (a == b) : (sum < b);

endmodule

// ===== rtl/arp_table.sv =====
// ----------------------------------------------------------------------------
// arp_table
// Pool storage: frame and handle memories, active bits in flops.
// ----------------------------------------------------------------------------
module arp_table #(
  parameter int DEPTH = 16,
  parameter int HW    = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  arp_pkg::tbl_ctl_t                 ctl,
  input  logic [$clog2(DEPTH)-1:0]          rd_addr,
  input  logic [$clog2(DEPTH)-1:0]          wr_addr,
  input  logic [$clog2(DEPTH)-1:0]          clr_addr,
  input  logic [arp_pkg::FRAME_BITS-1:0]    lf_wdata,
  input  logic [HW-1:0]                     hd_wdata,
  output logic [arp_pkg::FRAME_BITS-1:0]    lf_rd,
  output logic [HW-1:0]                     hd_rd,
  output logic [DEPTH-1:0]                  active
);
  import arp_pkg::*;

  logic [FRAME_BITS-1:0] lf_mem [DEPTH];
  logic [HW-1:0]         hd_mem [DEPTH];
  logic [DEPTH-1:0]      active_r;

  assign active = active_r;

  always_ff @(posedge clk) begin
    if (ctl.lf_we) begin
      lf_mem[wr_addr] <= lf_wdata;
    end
    if (ctl.hd_we) begin
      hd_mem[wr_addr] <= hd_wdata;
    end
    if (ctl.rd_en) begin
      lf_rd <= lf_mem[rd_addr];
      hd_rd <= hd_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      if (ctl.act_we) begin
        active_r[wr_addr] <= ctl.act_val;
      end
      if (ctl.act_clr) begin
        active_r[clr_addr] <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/aging_resource_pool_core.sv =====
// ----------------------------------------------------------------------------
// aging_resource_pool_core
// Handle pool with allocate, release and age-based eviction on frame ticks.
// ----------------------------------------------------------------------------
// Usage:
//   Drive in_word and raise start while busy is low; the word is taken at
//   that edge and busy rises until the result is out; func 3 answers
//   without raising busy. Each command answers with exactly one out_word,
//   shown for one cycle with out_valid high. The receiver cannot stall;
//   busy is already low in the out_valid cycle, so a new start can be
//   taken then.
//   Scan work (one entry examined per step):
//     allocate : entries up to the first inactive one on reuse, all of
//                them on append or full
//     release  : each active entry is read and its handle compared
//     tick     : each inactive entry's aged frame is compared; an evicted
//                one is refilled from the last entry and examined again
//     func 3   : answered as not found, with no scan
//   Rate is set by the single scan index walking the table, one memory read
//   per step, and by the one shared compare unit.
//   age_limit sits at APB byte address 0; write it only while idle.
//   Reset empties the pool, zeroes the frame counter and sets age_limit to 4.
//   No clearing pass: active bits are flops, the memories are only read
//   below the entry count.
// ----------------------------------------------------------------------------
module aging_resource_pool_core #(
  parameter int POOL_DEPTH  = 16,
  parameter int HANDLE_BITS = 32
) (
  input  logic              clk,
  input  logic              rst_n,
  // command channel
  input  logic              start,
  input  arp_pkg::arp_in_t  in_word,
  output logic              busy,
  // result channel
  output logic              out_valid,
  output arp_pkg::arp_out_t out_word,
  // config port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  import arp_pkg::*;

  localparam int AW   = $clog2(POOL_DEPTH);
  localparam int CW   = $clog2(POOL_DEPTH + 1);
  localparam int CMPW = (HANDLE_BITS > FRAME_BITS + 1) ? HANDLE_BITS : FRAME_BITS + 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  typedef enum logic [2:0] {
    S_IDLE, S_A_SCAN, S_A_OUT, S_R_SCAN, S_R_CMP, S_T_SCAN, S_T_CMP, S_T_MOVE
  } state_t;

  state_t                 state_r;
  logic [CW-1:0]          idx_r;
  logic [CW-1:0]          count_r;
  logic [CW-1:0]          ev_r;
  logic [FRAME_BITS-1:0]  frame_r;
  logic [HANDLE_BITS-1:0] hreq_r;
  logic [AGE_BITS-1:0]    age_r;
  logic                   out_valid_r;
  arp_out_t               out_word_r;

  // ---- config port ----
  logic cfg_wr;
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? 32'(age_r) : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      age_r <= AGE_BITS'(4);
    end else if (cfg_wr && paddr[2] == 1'b0) begin
      age_r <= pwdata[AGE_BITS-1:0];
    end
  end

  // ---- table and compare unit ----
  tbl_ctl_t               tctl;
  logic [AW-1:0]          rd_addr, wr_addr;
  logic [FRAME_BITS-1:0]  lf_wdata, lf_rd;
  logic [HANDLE_BITS-1:0] hd_wdata, hd_rd;
  logic [POOL_DEPTH-1:0]  active;
  cmp_op_t                cmp_op;
  logic [CMPW-1:0]        cmp_a, cmp_b;
  logic                   cmp_hit;

  logic          scan_end;
  logic [AW-1:0] idx_a, last_a;
  logic          act_i, act_last;

  assign scan_end = (idx_r >= count_r);
  assign idx_a    = idx_r[AW-1:0];
  assign last_a   = AW'(count_r - CW'(1));
  assign act_i    = active[idx_a];
  assign act_last = active[last_a];

  arp_table #(.DEPTH(POOL_DEPTH), .HW(HANDLE_BITS)) u_table (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (tctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .clr_addr (last_a),
    .lf_wdata (lf_wdata),
    .hd_wdata (hd_wdata),
    .lf_rd    (lf_rd),
    .hd_rd    (hd_rd),
    .active   (active)
  );

  // release compares handles, tick compares aged frames
  assign cmp_op = (state_r == S_R_CMP) ? CMP_EQ : CMP_LT;
  assign cmp_a  = (state_r == S_R_CMP) ? CMPW'(hd_rd) : CMPW'(lf_rd);
  assign cmp_b  = (state_r == S_R_CMP) ? CMPW'(hreq_r) : CMPW'(frame_r);

  arp_cmp_unit #(.W(CMPW)) u_cmp (
    .op     (cmp_op),
    .a      (cmp_a),
    .addend (age_r),
    .b      (cmp_b),
    .hit    (cmp_hit)
  );

  // ---- table control from sequencer state ----
  always_comb begin
    tctl     = '0;
    rd_addr  = idx_a;
    wr_addr  = idx_a;
    lf_wdata = frame_r;
    hd_wdata = hreq_r;
    tctl.act_val = 1'b1;
    case (state_r)
      S_A_SCAN: begin
        if (!scan_end && !act_i) begin
          // reuse: stamp frame, fetch stored handle
          tctl.act_we = 1'b1;
          tctl.lf_we  = 1'b1;
          tctl.rd_en  = 1'b1;
        end else if (scan_end && count_r < DEPTH_C) begin
          // append new entry
          wr_addr     = count_r[AW-1:0];
          tctl.act_we = 1'b1;
          tctl.lf_we  = 1'b1;
          tctl.hd_we  = 1'b1;
        end
      end
      S_R_SCAN: begin
        if (!scan_end && act_i) begin
          tctl.rd_en = 1'b1;
        end
      end
      S_R_CMP: begin
        if (cmp_hit) begin
          tctl.act_we  = 1'b1;
          tctl.act_val = 1'b0;
        end
      end
      S_T_SCAN: begin
        if (!scan_end && !act_i) begin
          tctl.rd_en = 1'b1;
        end
      end
      S_T_CMP: begin
        if (cmp_hit) begin
          // fetch last entry for the move
          tctl.rd_en = 1'b1;
          rd_addr    = last_a;
        end
      end
      S_T_MOVE: begin
        lf_wdata     = lf_rd;
        hd_wdata     = hd_rd;
        tctl.lf_we   = 1'b1;
        tctl.hd_we   = 1'b1;
        tctl.act_we  = 1'b1;
        tctl.act_val = act_last;
        tctl.act_clr = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // ---- sequencer ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      idx_r       <= '0;
      count_r     <= '0;
      ev_r        <= '0;
      frame_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            hreq_r <= HANDLE_BITS'(in_word.handle);
            idx_r  <= '0;
            ev_r   <= '0;
            case (in_word.func)
              FN_ALLOC:   state_r <= S_A_SCAN;
              FN_RELEASE: state_r <= S_R_SCAN;
              FN_TICK:    state_r <= S_T_SCAN;
              default: begin
                out_valid_r <= 1'b1;
                out_word_r  <= '{ST_NOT_FOUND, '0, '0, CNT_BITS'(count_r)};
              end
            endcase
          end
        end
        S_A_SCAN: begin
          if (!scan_end) begin
            if (!act_i) begin
              state_r <= S_A_OUT;
            end else begin
              idx_r <= idx_r + CW'(1);
            end
          end else if (count_r < DEPTH_C) begin
            count_r     <= count_r + CW'(1);
            out_valid_r <= 1'b1;
            out_word_r  <= '{ST_CREATED, WORD_BITS'(hreq_r), '0,
                             CNT_BITS'(count_r + CW'(1))};
            state_r     <= S_IDLE;
          end else begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{ST_FULL, '0, '0, CNT_BITS'(count_r)};
            state_r     <= S_IDLE;
          end
        end
        S_A_OUT: begin
          out_valid_r <= 1'b1;
          out_word_r  <= '{ST_REUSED, WORD_BITS'(hd_rd), '0, CNT_BITS'(count_r)};
          state_r     <= S_IDLE;
        end
        S_R_SCAN: begin
          if (scan_end) begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{ST_NOT_FOUND, '0, '0, CNT_BITS'(count_r)};
            state_r     <= S_IDLE;
          end else if (act_i) begin
            state_r <= S_R_CMP;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_R_CMP: begin
          if (cmp_hit) begin
            out_valid_r <= 1'b1;
            out_word_r  <= '{ST_RELEASED, '0, '0, CNT_BITS'(count_r)};
            state_r     <= S_IDLE;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_R_SCAN;
          end
        end
        S_T_SCAN: begin
          if (scan_end) begin
            if (frame_r != FRAME_MAX) begin
              frame_r <= frame_r + FRAME_BITS'(1);
            end
            out_valid_r <= 1'b1;
            out_word_r  <= '{ST_TICK_DONE, '0, CNT_BITS'(ev_r), CNT_BITS'(count_r)};
            state_r     <= S_IDLE;
          end else if (!act_i) begin
            state_r <= S_T_CMP;
          end else begin
            idx_r <= idx_r + CW'(1);
          end
        end
        S_T_CMP: begin
          if (cmp_hit) begin
            state_r <= S_T_MOVE;
          end else begin
            idx_r   <= idx_r + CW'(1);
            state_r <= S_T_SCAN;
          end
        end
        S_T_MOVE: begin
          // slot idx now holds the former last entry; examine it again
          count_r <= count_r - CW'(1);
          ev_r    <= ev_r + CW'(1);
          state_r <= S_T_SCAN;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // ---- assertions ----
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= DEPTH_C) else $error("entry count above pool depth");

  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result shown while still busy");

  a_accept_progress: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither started nor answered");

  a_frame_mono: assert property (@(posedge clk) disable iff (!rst_n)
    frame_r >= $past(frame_r)) else $error("frame counter went backward");

  a_evict_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_T_MOVE) |-> (count_r != '0 && idx_r < count_r))
    else $error("eviction move outside the pool");

endmodule

// ===== dv/aging_resource_pool_core_tb.sv =====
// ----------------------------------------------------------------------------
// aging_resource_pool_core_tb
// Self-checking bench for the handle pool: a directed table first, then
// random command phases at several age limits and sender idle rates. Every
// result word is checked against a local model of the pool table or a directed row's typed expectation.
// ----------------------------------------------------------------------------
module aging_resource_pool_core_tb;
  import arp_pkg::*;

  localparam int DEPTH       = 16;
  // worst tick: an eviction for every entry of a full table, plus margin
  localparam int SCAN_HOLD   = 3 * DEPTH + 12;
  // cycles with no word moving on either channel before the run is dropped
  localparam int STALL_LIMIT = 2000;
  localparam int N_PHASES    = 5;
  localparam int PHASE_ITEMS = 160;

  // func code with no operation behind it
  localparam logic [1:0] FN_UNUSED = 2'd3;
  // byte address of age_limit
  localparam logic [2:0] AGE_ADDR  = 3'd0;

  logic        clk;
  logic        rst_n;
  logic        start;
  arp_in_t     in_word;
  logic        busy;
  logic        out_valid;
  arp_out_t    out_word;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  aging_resource_pool_core #(
    .POOL_DEPTH (DEPTH),
    .HANDLE_BITS(32)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .in_word  (in_word),
    .busy     (busy),
    .out_valid(out_valid),
    .out_word (out_word),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Pool model: mirrors the table as seen from outside. Updated once per
  // accepted command word, in acceptance order.
  // --------------------------------------------------------------------------
  logic        pool_act   [DEPTH];
  logic [31:0] pool_frame [DEPTH];
  logic [31:0] pool_hdl   [DEPTH];
  int          pool_cnt;
  logic [31:0] frame_ctr;
  logic [7:0]  age_lim;

  arp_out_t    results_due[$];   // result words still owed by the block
  int          n_taken;          // command words accepted so far
  int          n_bad;
  int          idle_pct;         // sender idle chance, percent per cycle
  int          stall_cyc;

  // typed expectation riding along with a directed word
  bit          row_typed;
  arp_out_t    row_want;

  typedef struct {
    logic [1:0]  func;
    logic [31:0] hdl;
    int          reps;
    bit          typed;
    arp_out_t    want;
  } dir_row_t;

  dir_row_t    dir_rows[$];

  // Apply one command to the model and return the result word it owes.
  function automatic arp_out_t pool_op(arp_in_t w);
    arp_out_t         r;
    int               i;
    int               last;
    logic [4:0]       ev;
    logic [FRAME_BITS+1:0] aged;
    r  = '0;
    ev = '0;
    case (w.func)
      FN_ALLOC: begin
        // first inactive entry wins; otherwise append, else full
        for (i = 0; i < pool_cnt; i++)
          if (!pool_act[i]) break;
        if (i < pool_cnt) begin
          pool_act[i]   = 1'b1;
          pool_frame[i] = frame_ctr;
          r.status      = ST_REUSED;
          r.handle_out  = pool_hdl[i];
        end else if (pool_cnt < DEPTH) begin
          pool_act[pool_cnt]   = 1'b1;
          pool_frame[pool_cnt] = frame_ctr;
          pool_hdl[pool_cnt]   = w.handle;
          pool_cnt++;
          r.status     = ST_CREATED;
          r.handle_out = w.handle;
        end else begin
          r.status = ST_FULL;
        end
      end
      FN_RELEASE: begin
        r.status = ST_NOT_FOUND;
        for (i = 0; i < pool_cnt; i++) begin
          if (pool_act[i] && pool_hdl[i] == w.handle) begin
            pool_act[i] = 1'b0;
            r.status    = ST_RELEASED;
            break;
          end
        end
      end
      FN_TICK: begin
        // swap-with-last eviction; the refilled slot is looked at again
        i = 0;
        while (i < pool_cnt) begin
          aged = {2'b00, pool_frame[i]} + {{(FRAME_BITS-6){1'b0}}, age_lim};
          if (!pool_act[i] && aged < {2'b00, frame_ctr}) begin
            last           = pool_cnt - 1;
            pool_act[i]    = pool_act[last];
            pool_frame[i]  = pool_frame[last];
            pool_hdl[i]    = pool_hdl[last];
            pool_act[last] = 1'b0;
            pool_cnt       = last;
            ev++;
          end else begin
            i++;
          end
        end
        if (frame_ctr != FRAME_MAX) frame_ctr++;
        r.status  = ST_TICK_DONE;
        r.evicted = ev;
      end
      default: r.status = ST_NOT_FOUND;
    endcase
    r.entries = CNT_BITS'(pool_cnt);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge. A result word and a new
  // command can share an edge; the result belongs to an older command, so it
  // is checked before the new expectation is queued.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : mon
    arp_out_t got;
    arp_out_t want;
    if (rst_n) begin
      if (out_valid) begin
        got = out_word;
        if (results_due.size() == 0) begin
          n_bad++;
          $display("%0t: result word with none expected: expected none, got %h",
                   $time, got);
        end else begin
          want = results_due.pop_front();
          if (got.status !== want.status) begin
            n_bad++;
            $display("%0t: status mismatch: expected %0d, got %0d",
                     $time, want.status, got.status);
          end
          if (got.handle_out !== want.handle_out) begin
            n_bad++;
            $display("%0t: handle_out mismatch: expected %h, got %h",
                     $time, want.handle_out, got.handle_out);
          end
          if (got.evicted !== want.evicted) begin
            n_bad++;
            $display("%0t: evicted mismatch: expected %0d, got %0d",
                     $time, want.evicted, got.evicted);
          end
          if (got.entries !== want.entries) begin
            n_bad++;
            $display("%0t: entries mismatch: expected %0d, got %0d",
                     $time, want.entries, got.entries);
          end
        end
      end
      if (start && !busy) begin
        // model always advances; a typed row overrides what is expected
        want = pool_op(in_word);
        if (row_typed) want = row_want;
        results_due = {results_due, want};
        n_taken++;
      end
      if (psel && penable && pwrite && pready && paddr == AGE_ADDR)
        age_lim = pwdata[7:0];
    end
  end

  // watchdog: no command taken and no result out for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_valid) begin
        stall_cyc <= 0;
      end else if (stall_cyc >= STALL_LIMIT) begin
        $display("aging_resource_pool_core test failed");
        $finish;
      end else begin
        stall_cyc <= stall_cyc + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver tasks. All called at a falling edge; each returns at one.
  // --------------------------------------------------------------------------

  // Offer one command word, with random idle cycles first, and hold it until
  // taken. start only changes once per falling edge.
  task automatic send_word(input arp_in_t w, input bit t, input arp_out_t e);
    int tgt;
    while ($urandom_range(99) < idle_pct) begin
      start          = 1'b0;
      in_word.func   = 2'($urandom);
      in_word.handle = $urandom;
      @(negedge clk);
    end
    start     = 1'b1;
    in_word   = w;
    row_typed = t;
    row_want  = e;
    tgt       = n_taken + 1;
    do @(negedge clk); while (n_taken < tgt);
  endtask

  // stop sending and wait for every owed result word
  task automatic drain();
    start = 1'b0;
    while (results_due.size() != 0) @(negedge clk);
  endtask

  // APB write of age_limit; upper data bits are noise the block must drop
  task automatic cfg_write(input logic [7:0] v);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = AGE_ADDR;
    pwdata  = {24'($urandom), v};
    @(negedge clk);
    penable = 1'b1;
    do @(negedge clk); while (!pready);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    // read path shows the new limit, upper bits zero
    if (prdata !== {24'h0, v}) begin
      n_bad++;
      $display("%0t: age_limit readback mismatch: expected %h, got %h",
               $time, {24'h0, v}, prdata);
    end
  endtask

  task automatic add_row(input logic [1:0] f, input logic [31:0] h, input int n,
                         input bit t, input arp_out_t e);
    dir_row_t r;
    r.func  = f;
    r.hdl   = h;
    r.reps  = n;
    r.typed = t;
    r.want  = e;
    dir_rows = {dir_rows, r};
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    arp_in_t     w;
    int          p;
    int          k;
    int          n;
    int          roll;
    int          alloc_hi;
    logic [7:0]  age_set  [N_PHASES];
    int          idle_set [N_PHASES];
    int          alloc_set[N_PHASES];
    logic [31:0] live[$];

    clk       = 1'b0;
    rst_n     = 1'b0;
    start     = 1'b0;
    in_word   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;
    row_typed = 1'b0;
    row_want  = '0;
    n_taken   = 0;
    n_bad     = 0;
    idle_pct  = 0;
    stall_cyc = 0;

    // model reset state
    for (n = 0; n < DEPTH; n++) begin
      pool_act[n]   = 1'b0;
      pool_frame[n] = '0;
      pool_hdl[n]   = '0;
    end
    pool_cnt  = 0;
    frame_ctr = '0;
    age_lim   = 8'd4;

    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    // Directed table, age_limit at its reset value of 4. Typed rows are the
    // ones whose answer is obvious; the rest go through the model.
    // empty pool: release misses, unused func, first tick
    add_row(FN_RELEASE, 32'h0000_0000, 1, 1, {ST_NOT_FOUND, 32'h0, 5'd0, 5'd0});
    add_row(FN_UNUSED,  32'hFFFF_FFFF, 1, 1, {ST_NOT_FOUND, 32'h0, 5'd0, 5'd0});
    add_row(FN_TICK,    32'hFFFF_FFFF, 1, 1, {ST_TICK_DONE, 32'h0, 5'd0, 5'd0});
    // handle extremes appended
    add_row(FN_ALLOC, 32'hFFFF_FFFF, 1, 1, {ST_CREATED, 32'hFFFF_FFFF, 5'd0, 5'd1});
    add_row(FN_ALLOC, 32'h0000_0000, 1, 1, {ST_CREATED, 32'h0000_0000, 5'd0, 5'd2});
    add_row(FN_ALLOC, 32'hA5A5_5A5A, 1, 1, {ST_CREATED, 32'hA5A5_5A5A, 5'd0, 5'd3});
    // release hit, then the same handle misses once inactive
    add_row(FN_RELEASE, 32'hFFFF_FFFF, 1, 1, {ST_RELEASED,  32'h0, 5'd0, 5'd3});
    add_row(FN_RELEASE, 32'hFFFF_FFFF, 1, 1, {ST_NOT_FOUND, 32'h0, 5'd0, 5'd3});
    // reuse hands back the stored handle, not the request's
    add_row(FN_ALLOC, 32'h1234_5678, 1, 1, {ST_REUSED, 32'hFFFF_FFFF, 5'd0, 5'd3});
    add_row(FN_RELEASE, 32'h0000_0000, 1, 0, '0);
    add_row(FN_RELEASE, 32'hA5A5_5A5A, 1, 0, '0);
    // last tick evicts slot 1, pulls the tail in, and evicts it again
    add_row(FN_TICK,  32'h0, 6, 0, '0);
    // fill to the top, then one more allocate is refused
    add_row(FN_ALLOC, 32'h0000_FFFF, 15, 0, '0);
    add_row(FN_ALLOC, 32'h5A5A_5A5A, 1, 1, {ST_FULL, 32'h0, 5'd0, 5'd16});
    add_row(FN_RELEASE, 32'h0000_FFFF, 1, 0, '0);
    add_row(FN_ALLOC, 32'h0000_0000, 1, 0, '0);
    add_row(FN_TICK,  32'h0, 1, 0, '0);

    foreach (dir_rows[k]) begin
      for (n = 0; n < dir_rows[k].reps; n++) begin
        w.func   = dir_rows[k].func;
        w.handle = dir_rows[k].hdl;
        send_word(w, dir_rows[k].typed, dir_rows[k].want);
      end
    end

    // Random phases: age limit extremes and a random one; sender idle rate
    // 0, 85 and 18 percent (results cannot be held off, so only the sender
    // idles). Phase 1 leans on allocate so the pool fills.
    age_set[0] = 8'd0;    idle_set[0] = 0;  alloc_set[0] = 40;
    age_set[1] = 8'd255;  idle_set[1] = 85; alloc_set[1] = 60;
    age_set[2] = 8'd1;    idle_set[2] = 18; alloc_set[2] = 40;
    age_set[3] = 8'($urandom); idle_set[3] = 85; alloc_set[3] = 45;
    age_set[4] = 8'd4;    idle_set[4] = 0;  alloc_set[4] = 40;

    for (p = 0; p < N_PHASES; p++) begin
      // config only while idle: all results in, then let the scan settle
      drain();
      row_typed = 1'b0;
      repeat (SCAN_HOLD) @(negedge clk);
      cfg_write(age_set[p]);
      idle_pct = idle_set[p];
      alloc_hi = alloc_set[p];
      for (k = 0; k < PHASE_ITEMS; k++) begin
        // mid-phase: sender holds off until nothing is owed
        if (k == PHASE_ITEMS / 2) drain();
        roll     = $urandom_range(99);
        w.handle = $urandom_range(1) ? $urandom : (32'hC0DE_0000 | 32'($urandom_range(7)));
        if (roll < 4) begin
          w.func = FN_UNUSED;
        end else if (roll < alloc_hi) begin
          w.func = FN_ALLOC;
        end else if (roll < alloc_hi + 30) begin
          // mostly free a handle that is live right now
          w.func = FN_RELEASE;
          live.delete();
          for (n = 0; n < pool_cnt; n++)
            if (pool_act[n]) live = {live, pool_hdl[n]};
          if (live.size() != 0 && $urandom_range(9) < 8)
            w.handle = live[$urandom_range(live.size() - 1)];
        end else begin
          w.func = FN_TICK;
        end
        send_word(w, 1'b0, '0);
      end
    end

    drain();
    repeat (SCAN_HOLD) @(negedge clk);
    if (n_bad == 0 && results_due.size() == 0) begin
      $display("aging_resource_pool_core test passed");
    end else begin
      $display("aging_resource_pool_core test failed");
    end
    $finish;
  end

endmodule
